// ----- hw/rtl/stc_pkg.sv -----
// ----------------------------------------------------------------------------
// Splitter tree classifier package
// Widths, command codes and defaults shared by the classifier, its channel
// interfaces and its checker.
// ----------------------------------------------------------------------------
package stc_pkg;

	localparam int KEY_W        = 64;
	localparam int SLOT_W       = 10;
	localparam int BUCKET_W     = 11;
	// A slot plus one, as a one-based level-order index.
	localparam int LIDX_W       = SLOT_W + 1;
	localparam int TREE_LEVELS_DEF = 10;

	typedef enum logic [0:0] {
		CMD_LOAD     = 1'b0,
		CMD_CLASSIFY = 1'b1
	} cmd_t;

endpackage

// ----- hw/rtl/stc_in_if.sv -----
// ----------------------------------------------------------------------------
// Classifier command channel
// Valid/ready channel carrying one load or classify word.
// ----------------------------------------------------------------------------
interface stc_in_if;

	logic                         valid;
	logic                         ready;
	stc_pkg::cmd_t                command;
	logic [stc_pkg::SLOT_W-1:0]   slot;
	logic [stc_pkg::KEY_W-1:0]    key;

	modport source (output valid, output command, output slot, output key, input ready);
	modport sink   (input valid, input command, input slot, input key, output ready);

endinterface

// ----- hw/rtl/stc_out_if.sv -----
// ----------------------------------------------------------------------------
// Classifier result channel
// Valid/ready channel carrying one bucket word.
// ----------------------------------------------------------------------------
interface stc_out_if;

	logic                          valid;
	logic                          ready;
	logic [stc_pkg::BUCKET_W-1:0]  bucket;
	logic                          equal_hit;

	modport source (output valid, output bucket, output equal_hit, input ready);
	modport sink   (input valid, input bucket, input equal_hit, output ready);

endinterface

// ----- hw/rtl/splitter_tree_classifier.sv -----
// ----------------------------------------------------------------------------
// Splitter tree classifier
// Classifies 64-bit unsigned keys against a level-order tree of splitters.
// ----------------------------------------------------------------------------
// The items channel carries load words (write a splitter into a tree slot,
// no result) and classify words (one bucket word on the results channel).
// A slot at or beyond the tree size is ignored by a load.
// Each tree level has its own splitter store and its own pipeline stage, so
// one word is taken every cycle while the results channel does not stall;
// a classify word is loaded into the first level stage when it is taken,
// passes the level stages in order, then the output register after the last.
// Loads travel the same stages and write their level's
// store in order with the reads, so a classify sees every earlier load.
// Odd buckets mark a key equal to a splitter, even buckets a key between
// splitters.
// Reset clears the stage valid bits; the splitter stores hold nothing until
// loaded and must be loaded before keys are classified against them.
// When a result waits and the receiver is not ready, the whole pipeline
// holds and items.ready falls; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module splitter_tree_classifier #(
	parameter int TREE_LEVELS = stc_pkg::TREE_LEVELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	stc_in_if.sink      items,
	stc_out_if.source   results
);

	localparam int IW = TREE_LEVELS + 1;
	localparam int BW = (IW > stc_pkg::BUCKET_W) ? IW : stc_pkg::BUCKET_W;
	localparam int KW = stc_pkg::KEY_W;
	localparam int LW = stc_pkg::LIDX_W;

	logic adv;

	// Stage registers, one stage per tree level.
	logic          vld_s  [TREE_LEVELS];
	logic          cls_s  [TREE_LEVELS];
	logic [KW-1:0] key_s  [TREE_LEVELS];
	logic [IW-1:0] idx_s  [TREE_LEVELS];
	logic          hit_s  [TREE_LEVELS];
	logic [LW-1:0] lidx_s [TREE_LEVELS];
	logic [KW-1:0] spl_s  [TREE_LEVELS];

	// Values entering each stage.
	logic          f_vld  [TREE_LEVELS];
	logic          f_cls  [TREE_LEVELS];
	logic [KW-1:0] f_key  [TREE_LEVELS];
	logic [IW-1:0] f_idx  [TREE_LEVELS];
	logic          f_hit  [TREE_LEVELS];
	logic [LW-1:0] f_lidx [TREE_LEVELS];

	logic eq  [TREE_LEVELS];
	logic dir [TREE_LEVELS];

	logic                          out_vld_q;
	logic [stc_pkg::BUCKET_W-1:0]  bucket_q;
	logic                          hit_q;

	logic [IW-1:0]             fin_idx;
	logic                      fin_hit;
	logic [BW-1:0]             bkt_wide;

	assign adv         = !out_vld_q || results.ready;
	assign items.ready = adv;

	assign f_vld[0]  = items.valid;
	assign f_cls[0]  = (items.command == stc_pkg::CMD_CLASSIFY);
	assign f_key[0]  = items.key;
	assign f_idx[0]  = IW'(1);
	assign f_hit[0]  = 1'b0;
	assign f_lidx[0] = LW'(items.slot) + LW'(1);

	for (genvar d = 0; d < TREE_LEVELS; d++) begin : g_lvl
		localparam int DEPTH = 2 ** d;

		logic [KW-1:0] mem [DEPTH];
		logic          wr;
		logic [KW-1:0] rd_s;

		// Once a match is found the walk stops: the matching step shifts in
		// a one and every later step a zero, which leaves the in-order rank
		// in the low bits of the index.
		assign eq[d]    = (key_s[d] == spl_s[d]) && !hit_s[d];
		assign dir[d]   = eq[d] || (!hit_s[d] && (key_s[d] > spl_s[d]));
		assign spl_s[d] = rd_s;

		if (d > 0) begin : g_feed
			assign f_vld[d]  = vld_s[d-1];
			assign f_cls[d]  = cls_s[d-1];
			assign f_key[d]  = key_s[d-1];
			assign f_idx[d]  = {idx_s[d-1][IW-2:0], dir[d-1]};
			assign f_hit[d]  = hit_s[d-1] || eq[d-1];
			assign f_lidx[d] = lidx_s[d-1];
		end

		if (d < LW) begin : g_wr
			assign wr = adv && f_vld[d] && !f_cls[d] && ((f_lidx[d] >> d) == LW'(1));
		end else begin : g_nowr
			assign wr = 1'b0;
		end

		if (d == 0) begin : g_root
			always_ff @(posedge clk) begin
				if (wr) begin
					mem[0] <= f_key[d];
				end
				if (adv) begin
					rd_s <= mem[0];
				end
			end
		end else begin : g_node
			localparam int AW = d;

			logic [AW-1:0] wr_addr;

			assign wr_addr = AW'(f_lidx[d]);

			always_ff @(posedge clk) begin
				if (wr) begin
					mem[wr_addr] <= f_key[d];
				end
				if (adv) begin
					rd_s <= mem[f_idx[d][d-1:0]];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < TREE_LEVELS; d++) begin
				vld_s[d] <= 1'b0;
			end
			out_vld_q <= 1'b0;
		end else if (adv) begin
			for (int d = 0; d < TREE_LEVELS; d++) begin
				vld_s[d] <= f_vld[d];
			end
			out_vld_q <= vld_s[TREE_LEVELS-1] && cls_s[TREE_LEVELS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int d = 0; d < TREE_LEVELS; d++) begin
				cls_s[d]  <= f_cls[d];
				key_s[d]  <= f_key[d];
				idx_s[d]  <= f_idx[d];
				hit_s[d]  <= f_hit[d];
				lidx_s[d] <= f_lidx[d];
			end
			bucket_q <= bkt_wide[stc_pkg::BUCKET_W-1:0];
			hit_q    <= fin_hit;
		end
	end

	// The low TREE_LEVELS bits of the final index are the in-order rank on a
	// match, or the leaf gap otherwise.
	assign fin_idx  = {idx_s[TREE_LEVELS-1][IW-2:0], dir[TREE_LEVELS-1]};
	assign fin_hit  = hit_s[TREE_LEVELS-1] || eq[TREE_LEVELS-1];
	assign bkt_wide = BW'({fin_idx[TREE_LEVELS-1:0], 1'b0}) - BW'(fin_hit);

	assign results.valid     = out_vld_q;
	assign results.bucket    = bucket_q;
	assign results.equal_hit = hit_q;

endmodule

// ----- hw/rtl/stc_checker.sv -----
// ----------------------------------------------------------------------------
// Splitter tree classifier checker
// Port-level assertions on the result channel and flow control.
// ----------------------------------------------------------------------------
module stc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [stc_pkg::BUCKET_W-1:0]  bucket,
	input logic                          equal_hit
);

	// A held result stays offered until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(bucket) && $stable(equal_hit))
		else $error("result word changed while stalled");

	// Equal buckets are odd and gap buckets even.
	a_parity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (bucket[0] == equal_hit))
		else $error("bucket parity disagrees with equal_hit");

	// With no result waiting the pipeline must be free to move.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("items not accepted while the output is empty");

endmodule

bind splitter_tree_classifier stc_checker u_stc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (items.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.bucket    (results.bucket),
	.equal_hit (results.equal_hit)
);
